FILE: rtl/sto_pkg.sv
// shared types, constants and helpers for the segment to ellipsoid core
// no dependencies
package sto_pkg;

    localparam int PART_CAPACITY_DEF = 64;

    typedef enum logic [1:0] {
        K_CENTER = 2'd0,
        K_UAXIS  = 2'd1,
        K_VAXIS  = 2'd2,
        K_NAXIS  = 2'd3
    } t_kind;

    localparam logic [1:0] CFG_COS_YAW   = 2'd0;
    localparam logic [1:0] CFG_SIN_YAW   = 2'd1;
    localparam logic [1:0] CFG_COS_PITCH = 2'd2;
    localparam logic [1:0] CFG_SIN_PITCH = 2'd3;

    localparam logic [15:0] R0_MIN = 16'd41;
    localparam logic [15:0] R0_MAX = 16'd32767;
    localparam logic [17:0] UZ_LIMIT = 18'd36864;

    // one accepted segment as it travels from the front to the back
    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [16:0] dz;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
        logic [14:0] width;
        logic [14:0] thickness;
        logic [7:0]  material;
        logic [5:0]  idx;
    } t_seg;

    // back end sequencer states
    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_DIV, S_SIDE, S_SQRT2, S_DIV2, S_CROSS,
        S_ROT1, S_ROT2, S_EMIT
    } t_state;

    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        if (v > 36'sd32767) return 16'sh7fff;
        else if (v < -36'sd32768) return 16'sh8000;
        else return v[15:0];
    endfunction

    // round off the low 14 bits (rsh14) or 12 bits (rsh12), ties away from zero
    function automatic logic signed [35:0] rsh14(input logic signed [35:0] v);
        logic [35:0] m;
        m = v[35] ? 36'(-v) : 36'(v);
        m = (m + 36'd8192) >> 14;
        return v[35] ? 36'(-m) : 36'(m);
    endfunction

    function automatic logic signed [35:0] rsh12(input logic signed [35:0] v);
        logic [35:0] m;
        m = v[35] ? 36'(-v) : 36'(v);
        m = (m + 36'd2048) >> 12;
        return v[35] ? 36'(-m) : 36'(m);
    endfunction

endpackage

FILE: rtl/sto_front.sv
// front end: accepts segments, keeps the part counter, forms difference and midpoint
// depends on sto_pkg
module sto_front import sto_pkg::*; #(
    parameter int PART_CAPACITY = PART_CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_new_frame,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_start_z,
    input  logic signed [15:0] i_end_x,
    input  logic signed [15:0] i_end_y,
    input  logic signed [15:0] i_end_z,
    input  logic [14:0]       i_width,
    input  logic [14:0]       i_thickness,
    input  logic [7:0]        i_material,
    output logic              o_push,
    output t_seg              o_seg,
    input  logic              i_full
);
    localparam int CW = $clog2(PART_CAPACITY + 1);

    logic [CW-1:0] r_count, n_count, base;
    logic acc, keep;

    assign o_stall = i_full;
    assign acc  = i_valid && !i_full;
    assign base = i_new_frame ? '0 : r_count;
    assign keep = base < CW'(PART_CAPACITY);
    assign o_push = acc && keep;

    always_comb begin
        n_count = r_count;
        if (acc) n_count = keep ? base + 1'b1 : base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= '0;
        else r_count <= n_count;
    end

    logic signed [16:0] sx, sy, sz;
    always_comb begin
        sx = 17'(i_start_x) + 17'(i_end_x);
        sy = 17'(i_start_y) + 17'(i_end_y);
        sz = 17'(i_start_z) + 17'(i_end_z);
        o_seg.dx = 17'(i_end_x) - 17'(i_start_x);
        o_seg.dy = 17'(i_end_y) - 17'(i_start_y);
        o_seg.dz = 17'(i_end_z) - 17'(i_start_z);
        o_seg.mx = sx[16:1];
        o_seg.my = sy[16:1];
        o_seg.mz = sz[16:1];
        o_seg.width = i_width;
        o_seg.thickness = i_thickness;
        o_seg.material = i_material;
        o_seg.idx = 6'(base);
    end
endmodule

FILE: rtl/sto_fifo.sv
// short queue between front and back ends
// depends on sto_pkg
module sto_fifo import sto_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_seg i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_seg o_data
);
    t_seg r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

FILE: rtl/sto_back.sv
// back end: length, normalization, cross products, rotation and row output
// depends on sto_pkg
module sto_back import sto_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_seg i_seg,
    output logic o_pop,
    input  logic signed [15:0] i_cos_yaw,
    input  logic signed [15:0] i_sin_yaw,
    input  logic signed [15:0] i_cos_pitch,
    input  logic signed [15:0] i_sin_pitch,
    output logic o_valid,
    input  logic i_stall,
    output logic [1:0] o_row_kind,
    output logic signed [15:0] o_coord_x,
    output logic signed [15:0] o_coord_y,
    output logic signed [15:0] o_coord_z,
    output logic [14:0] o_radius,
    output logic [7:0]  o_material_out,
    output logic [5:0]  o_part_index,
    output logic        o_last_row
);
    t_state r_st, n_st;
    t_seg r_seg;
    logic [35:0] r_ss;
    logic [17:0] r_rt, r_rem;
    logic [4:0]  r_it;
    logic [1:0]  r_lane, r_row;
    logic [30:0] r_num, r_q;
    logic [16:0] r_len;
    logic [16:0] r_seglen;
    logic signed [15:0] r_u [3];
    logic signed [15:0] r_v [3];
    logic signed [15:0] r_n [3];
    logic signed [16:0] r_w [3];
    logic signed [35:0] r_bx, r_by, r_az;
    logic signed [15:0] r_ox, r_oy, r_oz;
    logic r_ov;
    logic [5:0] r_dit;
    logic r_second;

    logic out_free;
    assign out_free = !r_ov || !i_stall;

    // current row vector
    logic signed [15:0] vx, vy, vz;
    always_comb begin
        case (r_row)
            K_CENTER: begin vx = r_seg.mx; vy = r_seg.my; vz = r_seg.mz; end
            K_UAXIS:  begin vx = r_u[0]; vy = r_u[1]; vz = r_u[2]; end
            K_VAXIS:  begin vx = r_v[0]; vy = r_v[1]; vz = r_v[2]; end
            default:  begin vx = r_n[0]; vy = r_n[1]; vz = r_n[2]; end
        endcase
    end

    // radius selection, len * 54 / 100 by reciprocal multiplication
    logic [15:0] r0a;
    logic [22:0] l54;
    logic [46:0] l54m;
    logic [14:0] rad;
    always_comb begin
        l54 = 23'(r_seglen) * 23'd54;
        l54m = 47'(l54) * 47'd10737419;
        r0a = l54m[45:30];
        if (r0a < R0_MIN) r0a = R0_MIN;
        if (r0a > R0_MAX) r0a = R0_MAX;
        case (r_row)
            K_CENTER: rad = '0;
            K_UAXIS:  rad = r0a[14:0];
            K_VAXIS:  rad = r_seg.width;
            default:  rad = r_seg.thickness;
        endcase
    end

    // divider source: magnitude of numerator lane
    logic signed [16:0] dl;
    logic signed [31:0] dnum;
    always_comb begin
        if (r_second) dl = r_w[r_lane];
        else begin
            case (r_lane)
                2'd0: dl = r_seg.dx;
                2'd1: dl = r_seg.dy;
                default: dl = r_seg.dz;
            endcase
        end
        dnum = 32'(dl) * 32'sd4096;
    end

    logic [31:0] dmag;
    assign dmag = dnum[31] ? 32'(-dnum) : 32'(dnum);

    // restoring sqrt step
    logic [19:0] sq_t;
    logic [19:0] sq_trial;
    always_comb begin
        sq_t = {r_rem, r_ss[35:34]};
        sq_trial = {r_rt, 2'b01};
    end

    // divider step, dividend 2*mag+len, divisor 2*len
    logic [32:0] dv_rem_s, dv_d;
    logic [32:0] r_drem;
    assign dv_d = {15'd0, r_len, 1'b0};
    assign dv_rem_s = {r_drem[31:0], r_num[30]};

    logic signed [15:0] qs;
    always_comb begin
        qs = 16'(r_q);
        if (dl < 0) qs = -qs;
    end

    logic [15:0] uza;
    logic [19:0] uz10;
    assign uza = r_u[2][15] ? 16'(-r_u[2]) : 16'(r_u[2]);
    assign uz10 = 20'(uza) * 20'd10;

    logic signed [31:0] c0, c1, c2;
    always_comb begin
        c0 = 32'(r_u[1]) * 32'(r_v[2]) - 32'(r_u[2]) * 32'(r_v[1]);
        c1 = 32'(r_u[2]) * 32'(r_v[0]) - 32'(r_u[0]) * 32'(r_v[2]);
        c2 = 32'(r_u[0]) * 32'(r_v[1]) - 32'(r_u[1]) * 32'(r_v[0]);
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (!i_empty) n_st = S_SQ;
            S_SQ:    n_st = S_SQRT;
            S_SQRT:  if (r_it == 5'd18) n_st = r_second ? S_DIV2 : S_DIV;
            S_DIV:   if (r_len == 0 || (r_dit == 6'd32 && r_lane == 2'd2)) n_st = S_SIDE;
            S_SIDE:  n_st = S_SQRT2;
            S_SQRT2: n_st = S_SQRT;
            S_DIV2:  if (r_len == 0 || (r_dit == 6'd32 && r_lane == 2'd2)) n_st = S_CROSS;
            S_CROSS: n_st = S_ROT1;
            S_ROT1:  n_st = S_ROT2;
            S_ROT2:  n_st = S_EMIT;
            S_EMIT:  if (out_free) n_st = (r_row == K_NAXIS) ? S_IDLE : S_ROT1;
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_st == S_IDLE) && !i_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_EMIT && out_free) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_seg <= i_seg;
                r_second <= 1'b0;
                r_row <= K_CENTER;
            end
            S_SQ: begin
                r_ss <= 36'(r_seg.dx) * 36'(r_seg.dx) + 36'(r_seg.dy) * 36'(r_seg.dy)
                      + 36'(r_seg.dz) * 36'(r_seg.dz);
                r_rem <= '0; r_rt <= '0; r_it <= '0;
            end
            S_SQRT: begin
                r_ss <= r_ss << 2;
                r_it <= r_it + 1'b1;
                if (r_it != 5'd18) begin
                    if (sq_t >= sq_trial) begin
                        r_rem <= 18'(sq_t - sq_trial);
                        r_rt  <= {r_rt[16:0], 1'b1};
                    end else begin
                        r_rem <= sq_t[17:0];
                        r_rt  <= {r_rt[16:0], 1'b0};
                    end
                end else begin
                    r_len <= r_rt[16:0];
                    if (!r_second) r_seglen <= r_rt[16:0];
                    r_lane <= 2'd0; r_dit <= '0; r_drem <= '0; r_q <= '0;
                end
            end
            S_DIV, S_DIV2: begin
                if (r_len == 0) begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_second) r_v[i] <= '0; else r_u[i] <= '0;
                    end
                end else if (r_dit == 6'd0) begin
                    // load the numerator of this lane
                    r_num <= {dmag[29:0], 1'b0} + 31'(r_len);
                    r_drem <= '0; r_q <= '0;
                    r_dit <= r_dit + 1'b1;
                end else if (r_dit == 6'd32) begin
                    if (r_second) r_v[r_lane] <= qs; else r_u[r_lane] <= qs;
                    r_lane <= r_lane + 1'b1;
                    r_dit <= '0;
                end else begin
                    r_num <= r_num << 1;
                    r_dit <= r_dit + 1'b1;
                    if (dv_rem_s >= dv_d) begin
                        r_drem <= dv_rem_s - dv_d;
                        r_q <= {r_q[29:0], 1'b1};
                    end else begin
                        r_drem <= dv_rem_s;
                        r_q <= {r_q[29:0], 1'b0};
                    end
                end
            end
            S_SIDE: begin
                r_second <= 1'b1;
                if (18'(uz10) > UZ_LIMIT) begin
                    r_w[0] <= 17'(r_u[2]); r_w[1] <= '0; r_w[2] <= -17'(r_u[0]);
                end else begin
                    r_w[0] <= -17'(r_u[1]); r_w[1] <= 17'(r_u[0]); r_w[2] <= '0;
                end
            end
            S_SQRT2: begin
                r_ss <= 36'(r_w[0]) * 36'(r_w[0]) + 36'(r_w[1]) * 36'(r_w[1])
                      + 36'(r_w[2]) * 36'(r_w[2]);
                r_rem <= '0; r_rt <= '0; r_it <= '0;
            end
            S_CROSS: begin
                r_n[0] <= 16'(rsh12(36'(c0)));
                r_n[1] <= 16'(rsh12(36'(c1)));
                r_n[2] <= 16'(rsh12(36'(c2)));
            end
            S_ROT1: begin
                r_bx <= rsh14(36'(32'(i_cos_yaw) * 32'(vx)) - 36'(32'(i_sin_yaw) * 32'(vy)));
                r_by <= rsh14(36'(32'(i_sin_yaw) * 32'(vx)) + 36'(32'(i_cos_yaw) * 32'(vy)));
                r_az <= 36'(vz);
            end
            S_ROT2: begin
                r_ox <= sat16(r_bx);
                r_oy <= sat16(rsh14(36'(i_cos_pitch) * r_by - 36'(i_sin_pitch) * r_az));
                r_oz <= sat16(rsh14(36'(i_sin_pitch) * r_by + 36'(i_cos_pitch) * r_az));
            end
            S_EMIT: begin
                if (out_free) begin
                    o_row_kind <= r_row;
                    o_coord_x <= r_ox; o_coord_y <= r_oy; o_coord_z <= r_oz;
                    o_radius <= rad;
                    o_material_out <= r_seg.material;
                    o_part_index <= r_seg.idx;
                    o_last_row <= r_row == K_NAXIS;
                    r_row <= r_row + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_ov;
endmodule

FILE: rtl/segment_to_oriented_ellipsoid_core.sv
// Segment to oriented ellipsoid core. Each accepted request yields four rows
// (center, u, v, n axis) unless the frame's part capacity is reached. The back
// end is a sequencer with a bit-serial square root (run twice) and a restoring
// divider (six components); a two-deep queue lets the front take two more
// requests while the back end works on a segment. Trig registers must only be
// written while idle.
module segment_to_oriented_ellipsoid_core import sto_pkg::*; #(
    parameter int PART_CAPACITY = PART_CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic i_valid,
    output logic o_stall,
    input  logic i_new_frame,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_start_z,
    input  logic signed [15:0] i_end_x,
    input  logic signed [15:0] i_end_y,
    input  logic signed [15:0] i_end_z,
    input  logic [14:0] i_width,
    input  logic [14:0] i_thickness,
    input  logic [7:0]  i_material,
    output logic o_valid,
    input  logic i_stall,
    output logic [1:0] o_row_kind,
    output logic signed [15:0] o_coord_x,
    output logic signed [15:0] o_coord_y,
    output logic signed [15:0] o_coord_z,
    output logic [14:0] o_radius,
    output logic [7:0]  o_material_out,
    output logic [5:0]  o_part_index,
    output logic        o_last_row
);
    logic signed [15:0] r_cy, r_sy, r_cp, r_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cy <= 16'sd16384; r_sy <= '0; r_cp <= 16'sd16384; r_sp <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COS_YAW:   r_cy <= i_cfg_data;
                CFG_SIN_YAW:   r_sy <= i_cfg_data;
                CFG_COS_PITCH: r_cp <= i_cfg_data;
                CFG_SIN_PITCH: r_sp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic push, full, pop, empty;
    t_seg fseg, bseg;

    sto_front #(.PART_CAPACITY(PART_CAPACITY)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_new_frame,
        .i_start_x, .i_start_y, .i_start_z, .i_end_x, .i_end_y, .i_end_z,
        .i_width, .i_thickness, .i_material,
        .o_push(push), .o_seg(fseg), .i_full(full)
    );

    sto_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(push), .i_data(fseg), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_data(bseg)
    );

    sto_back u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_seg(bseg), .o_pop(pop),
        .i_cos_yaw(r_cy), .i_sin_yaw(r_sy), .i_cos_pitch(r_cp), .i_sin_pitch(r_sp),
        .o_valid, .i_stall, .o_row_kind, .o_coord_x, .o_coord_y, .o_coord_z,
        .o_radius, .o_material_out, .o_part_index, .o_last_row
    );

`ifndef ASSERT_OFF
    a_center_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_row_kind == K_CENTER |-> o_radius == '0)
        else $error("center row radius nonzero");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_row == (o_row_kind == K_NAXIS)))
        else $error("last row flag mismatch");
    a_fifo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full) && !(pop && empty))
        else $error("queue overflow or underflow");
`endif
endmodule

FILE: sim/testbench.sv
// testbench for segment_to_oriented_ellipsoid_core: directed, config, capacity and random tests
// predicts every row in fixed point and checks the output stream in order; depends on sto_pkg
module testbench;
    import sto_pkg::*;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [15:0] i_cfg_data;
    logic i_valid, o_stall, i_new_frame;
    logic signed [15:0] i_start_x, i_start_y, i_start_z, i_end_x, i_end_y, i_end_z;
    logic [14:0] i_width, i_thickness;
    logic [7:0] i_material;
    logic o_valid, i_stall;
    logic [1:0] o_row_kind;
    logic signed [15:0] o_coord_x, o_coord_y, o_coord_z;
    logic [14:0] o_radius;
    logic [7:0] o_material_out;
    logic [5:0] o_part_index;
    logic o_last_row;

    typedef struct {
        logic new_frame;
        logic signed [15:0] sx, sy, sz, ex, ey, ez;
        logic [14:0] wid, thk;
        logic [7:0] mat;
    } seg_t;

    typedef struct {
        t_kind kind;
        logic signed [15:0] x, y, z;
        logic [14:0] rad;
        logic [7:0] mat;
        logic [5:0] idx;
        logic last;
    } row_t;

    row_t expected_rows[$];
    longint cos_yaw_m, sin_yaw_m, cos_pitch_m, sin_pitch_m;
    int parts_used;
    int errors;
    int burst_left;
    int unsigned cyc;

    segment_to_oriented_ellipsoid_core dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

    function automatic longint int_sqrt(longint x);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // round(n/d), ties away from zero
    function automatic longint div_round(longint n, longint d);
        longint m, q;
        m = n < 0 ? -n : n;
        q = (2 * m + d) / (2 * d);
        return n < 0 ? -q : q;
    endfunction

    function automatic longint shift_round(longint v, int sh);
        longint m, q;
        m = v < 0 ? -v : v;
        q = (m + (longint'(1) << (sh - 1))) >> sh;
        return v < 0 ? -q : q;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic void normalize(input longint w[3], output longint r[3]);
        longint l;
        l = int_sqrt(w[0] * w[0] + w[1] * w[1] + w[2] * w[2]);
        for (int i = 0; i < 3; i++) r[i] = l > 0 ? div_round(w[i] * 4096, l) : 0;
    endfunction

    // midpoint plus frame axes of one segment, rotated by yaw then pitch
    function automatic void predict_part(seg_t s);
        longint st[3], en[3], d[3], vec[4][3], w[3], v3[3], u3[3], len, r0, bx, by;
        longint radii[4];
        row_t r;
        logic [5:0] slot;
        if (s.new_frame) parts_used = 0;
        if (parts_used >= PART_CAPACITY_DEF) return;
        slot = parts_used[5:0];
        parts_used++;
        st = '{s.sx, s.sy, s.sz};
        en = '{s.ex, s.ey, s.ez};
        for (int i = 0; i < 3; i++) begin
            d[i] = en[i] - st[i];
            vec[0][i] = (st[i] + en[i]) >>> 1;
        end
        len = int_sqrt(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]);
        for (int i = 0; i < 3; i++) u3[i] = len > 0 ? div_round(d[i] * 4096, len) : 0;
        // up vector switches to y when u is nearly vertical
        if ((u3[2] < 0 ? -u3[2] : u3[2]) * 10 > 36864) w = '{u3[2], 0, -u3[0]};
        else w = '{-u3[1], u3[0], 0};
        normalize(w, v3);
        vec[1] = u3;
        vec[2] = v3;
        vec[3][0] = shift_round(u3[1] * v3[2] - u3[2] * v3[1], 12);
        vec[3][1] = shift_round(u3[2] * v3[0] - u3[0] * v3[2], 12);
        vec[3][2] = shift_round(u3[0] * v3[1] - u3[1] * v3[0], 12);
        r0 = len * 54 / 100;
        if (r0 < 41) r0 = 41;
        if (r0 > 32767) r0 = 32767;
        radii = '{0, r0, s.wid, s.thk};
        for (int k = 0; k < 4; k++) begin
            bx = shift_round(cos_yaw_m * vec[k][0] - sin_yaw_m * vec[k][1], 14);
            by = shift_round(sin_yaw_m * vec[k][0] + cos_yaw_m * vec[k][1], 14);
            r.kind = t_kind'(k);
            r.x = clamp16(bx);
            r.y = clamp16(shift_round(cos_pitch_m * by - sin_pitch_m * vec[k][2], 14));
            r.z = clamp16(shift_round(sin_pitch_m * by + cos_pitch_m * vec[k][2], 14));
            r.rad = radii[k][14:0];
            r.mat = s.mat;
            r.idx = slot;
            r.last = (k == 3);
            expected_rows.push_back(r);
        end
    endfunction

    // row checker and receiver stall pattern
    always @(posedge i_clk) begin
        row_t e;
        cyc <= cyc + 1;
        case ((cyc / 300) % 3)
            0: i_stall <= 1'b0;
            1: i_stall <= 1'($urandom_range(0, 1));
            default: i_stall <= (cyc % 23) < 15;
        endcase
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rows.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected row kind=%0d idx=%0d", o_row_kind,
                    o_part_index);
            end else begin
                e = expected_rows.pop_front();
                if (o_row_kind !== e.kind || o_coord_x !== e.x || o_coord_y !== e.y ||
                    o_coord_z !== e.z || o_radius !== e.rad || o_material_out !== e.mat ||
                    o_part_index !== e.idx || o_last_row !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch exp k%0d (%0d,%0d,%0d) r%0d m%0d i%0d l%0d",
                            " got k%0d (%0d,%0d,%0d) r%0d m%0d i%0d l%0d"},
                            e.kind, e.x, e.y, e.z, e.rad, e.mat, e.idx, e.last,
                            o_row_kind, o_coord_x, o_coord_y, o_coord_z, o_radius,
                            o_material_out, o_part_index, o_last_row);
                end
            end
        end
    end

    task automatic send_segment(seg_t s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_new_frame <= s.new_frame;
        i_start_x <= s.sx; i_start_y <= s.sy; i_start_z <= s.sz;
        i_end_x <= s.ex; i_end_y <= s.ey; i_end_z <= s.ez;
        i_width <= s.wid; i_thickness <= s.thk; i_material <= s.mat;
        do @(posedge i_clk); while (o_stall);
        predict_part(s);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        wait (expected_rows.size() == 0);
        // a dropped request may still be in flight
        repeat (800) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic signed [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_COS_YAW: cos_yaw_m = val;
            CFG_SIN_YAW: sin_yaw_m = val;
            CFG_COS_PITCH: cos_pitch_m = val;
            default: sin_pitch_m = val;
        endcase
    endtask

    task automatic set_angles(logic signed [15:0] cy, sy, cp, sp);
        drain();
        write_reg(CFG_COS_YAW, cy);
        write_reg(CFG_SIN_YAW, sy);
        write_reg(CFG_COS_PITCH, cp);
        write_reg(CFG_SIN_PITCH, sp);
    endtask

    function automatic seg_t rand_segment(logic nf);
        seg_t s;
        int sc;
        s.new_frame = nf;
        sc = $urandom_range(0, 3);
        s.sx = 16'($urandom); s.sy = 16'($urandom); s.sz = 16'($urandom);
        s.ex = 16'($urandom); s.ey = 16'($urandom); s.ez = 16'($urandom);
        // shorter segments around an anchor most of the time
        if (sc != 0) begin
            s.ex = s.sx + ($signed(16'($urandom)) >>> (sc * 3));
            s.ey = s.sy + ($signed(16'($urandom)) >>> (sc * 3));
            s.ez = s.sz + ($signed(16'($urandom)) >>> (sc * 3));
        end
        s.wid = 15'($urandom); s.thk = 15'($urandom); s.mat = 8'($urandom);
        return s;
    endfunction

    function automatic seg_t mk(logic nf, int sx, sy, sz, ex, ey, ez, wd, th, m);
        seg_t s;
        s = '{nf, sx, sy, sz, ex, ey, ez, wd, th, m};
        return s;
    endfunction

    task automatic test_directed;
        send_segment(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));              // zero length
        send_segment(mk(0, 0, 0, 0, 4096, 0, 0, 4096, 2048, 1));
        send_segment(mk(0, 0, 0, 0, 0, 0, 4096, 100, 200, 2));       // vertical, y up
        send_segment(mk(0, 0, 0, 4096, 0, 0, -4096, 1, 1, 3));
        send_segment(mk(0, 100, 200, 0, 300, 100, 2000, 5, 6, 4));
        send_segment(mk(0, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 255));
        send_segment(mk(0, 32767, 32767, 32767, -32768, -32768, -32768, 0, 32767, 128));
        send_segment(mk(0, 32767, -32768, 0, -32768, 32767, 0, 21845, 10922, 85));
        send_segment(mk(0, 0, 0, 0, 1, 0, 0, 7, 8, 170));            // tiny segment
        send_segment(mk(0, 0, 0, 0, 0, 0, 1, 7, 8, 9));
        send_segment(mk(0, 5, 5, 5, 5, 5, 5, 9, 9, 10));
        send_segment(mk(0, -1, -1, -1, 0, 0, 0, 3, 3, 11));
        send_segment(mk(0, 0, 0, 0, 1000, 1000, 8000, 4, 4, 12));    // near the switch
    endtask

    task automatic test_config;
        logic signed [15:0] vals[6];
        vals = '{16384, -16384, 0, 11585, 32767, -32768};
        for (int i = 0; i < 6; i++) begin
            set_angles(vals[i], vals[(i + 3) % 6], vals[(i + 1) % 6], vals[(i + 4) % 6]);
            for (int j = 0; j < 6; j++) send_segment(rand_segment(j == 0));
        end
        set_angles(16384, 0, 16384, 0);
    endtask

    task automatic test_capacity;
        // fill one frame past its capacity, then restart with a new frame
        for (int i = 0; i < PART_CAPACITY_DEF + 6; i++) send_segment(rand_segment(i == 0));
        send_segment(rand_segment(1));
    endtask

    task automatic test_random;
        for (int i = 0; i < 40; i++) begin
            if (i % 40 == 20)
                set_angles(16'($urandom_range(0, 32768) - 16384),
                    16'($urandom_range(0, 32768) - 16384),
                    16'($urandom_range(0, 32768) - 16384),
                    16'($urandom_range(0, 32768) - 16384));
            send_segment(rand_segment($urandom_range(0, 15) == 0));
        end
    endtask

    initial begin
        errors = 0;
        burst_left = 0;
        cyc = 0;
        parts_used = 0;
        cos_yaw_m = 16384; sin_yaw_m = 0; cos_pitch_m = 16384; sin_pitch_m = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_new_frame = 1'b0;
        i_start_x = '0; i_start_y = '0; i_start_z = '0;
        i_end_x = '0; i_end_y = '0; i_end_z = '0;
        i_width = '0; i_thickness = '0; i_material = '0;
        i_stall = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config();
        test_capacity();
        test_random();
        drain();
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
